// File: rtl/crcfb_pkg.sv
// crcfb_pkg: shared types, register indexes and crc helper for the frame builder
`default_nettype none

package crcfb_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [BYTE_W-1:0] START_BYTE_RST     = 8'hAA;
    localparam logic [BYTE_W-1:0] FRAME_TYPE_RST     = 8'h01;
    localparam logic [LEN_W-1:0]  PAYLOAD_LENGTH_RST = 16'd73;
    localparam logic              CORRUPT_CHECK_RST  = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE     = 2'd0,
        REG_FRAME_TYPE     = 2'd1,
        REG_PAYLOAD_LENGTH = 2'd2,
        REG_CORRUPT_CHECK  = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_CHK_LO,
        PH_CHK_HI
    } phase_t;

    // one byte of crc-16/ccitt-false, msb first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/crc16_frame_builder.sv
// crc16_frame_builder: byte framer with header, pass-through payload and crc-16 trailer
// path: a payload byte is held in the item registers, then in the output register;
// one that opens a frame goes out after the start, type and two length beats
// throughput: one output beat per cycle from the single emit stage while not stalled;
// an input beat every cycle mid-frame, held off while header and trailer beats go out
// reset: config registers take their reset values, no frame open, crc at 0xffff, no beats held
`default_nettype none

module crc16_frame_builder
    import crcfb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [BYTE_W-1:0]     payload_byte,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [BYTE_W-1:0]          out_byte,
    output logic                       run_last,
    output logic                       frame_end
);

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] frame_type_reg;
    logic [LEN_W-1:0]  payload_length_reg;
    logic              corrupt_check_reg;

    logic [LEN_W-1:0]  bytes_taken_reg;
    logic [LEN_W-1:0]  bytes_taken_next;
    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_next;

    logic              item_valid_reg;
    logic              item_valid_next;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [BYTE_W-1:0] item_start_reg;
    logic [BYTE_W-1:0] item_type_reg;
    logic [LEN_W-1:0]  item_len_reg;
    logic              item_flip_reg;
    logic              item_close_reg;
    logic [BYTE_W-1:0] item_data_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;
    logic              frame_end_reg;

    logic              in_accept;
    logic              emit;
    logic              emit_last;
    logic              emit_end;
    logic [BYTE_W-1:0] emit_byte;
    logic [BYTE_W-1:0] flip_mask;
    logic [LEN_W-1:0]  taken_plus;
    logic              frame_open;
    logic              frame_close;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg     <= START_BYTE_RST;
            frame_type_reg     <= FRAME_TYPE_RST;
            payload_length_reg <= PAYLOAD_LENGTH_RST;
            corrupt_check_reg  <= CORRUPT_CHECK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_BYTE:     start_byte_reg     <= cfg_data[BYTE_W-1:0];
                REG_FRAME_TYPE:     frame_type_reg     <= cfg_data[BYTE_W-1:0];
                REG_PAYLOAD_LENGTH: payload_length_reg <= cfg_data[LEN_W-1:0];
                REG_CORRUPT_CHECK:  corrupt_check_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // input side
    assign in_accept   = in_valid && !in_stall;
    assign taken_plus  = bytes_taken_reg + LEN_W'(1);
    assign frame_open  = (bytes_taken_reg == '0);
    assign frame_close = (taken_plus == payload_length_reg);
    assign in_stall    = item_valid_reg && !(emit && emit_last);

    always_comb
    begin
        bytes_taken_next = bytes_taken_reg;
        if (in_accept)
        begin
            bytes_taken_next = frame_close ? '0 : taken_plus;
        end
    end

    // emit stage
    assign emit      = item_valid_reg && (!out_valid_reg || !out_stall);
    assign flip_mask = {BYTE_W{item_flip_reg}};

    always_comb
    begin
        emit_byte  = item_data_reg;
        emit_last  = 1'b0;
        emit_end   = 1'b0;
        crc_next   = crc_reg;
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_START:
            begin
                emit_byte  = item_start_reg;
                crc_next   = CRC_INIT;
                phase_next = PH_TYPE;
            end
            PH_TYPE:
            begin
                emit_byte  = item_type_reg;
                crc_next   = crc16_byte(crc_reg, item_type_reg);
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                emit_byte  = item_len_reg[BYTE_W-1:0];
                crc_next   = crc16_byte(crc_reg, item_len_reg[BYTE_W-1:0]);
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                emit_byte  = item_len_reg[LEN_W-1:BYTE_W];
                crc_next   = crc16_byte(crc_reg, item_len_reg[LEN_W-1:BYTE_W]);
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                emit_byte  = item_data_reg;
                crc_next   = crc16_byte(crc_reg, item_data_reg);
                emit_last  = !item_close_reg;
                phase_next = PH_CHK_LO;
            end
            PH_CHK_LO:
            begin
                emit_byte  = crc_reg[BYTE_W-1:0] ^ flip_mask;
                phase_next = PH_CHK_HI;
            end
            PH_CHK_HI:
            begin
                emit_byte  = crc_reg[CRC_W-1:BYTE_W] ^ flip_mask;
                emit_last  = 1'b1;
                emit_end   = 1'b1;
                crc_next   = CRC_INIT;
                phase_next = PH_START;
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
        if (!emit)
        begin
            crc_next   = crc_reg;
            phase_next = phase_reg;
        end
        if (in_accept)
        begin
            phase_next = frame_open ? PH_START : PH_DATA;
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (emit && emit_last)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_taken_reg <= '0;
            crc_reg         <= CRC_INIT;
            item_valid_reg  <= 1'b0;
            phase_reg       <= PH_START;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            bytes_taken_reg <= bytes_taken_next;
            crc_reg         <= crc_next;
            item_valid_reg  <= item_valid_next;
            phase_reg       <= phase_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_start_reg <= start_byte_reg;
            item_type_reg  <= frame_type_reg;
            item_len_reg   <= payload_length_reg;
            item_flip_reg  <= corrupt_check_reg;
            item_close_reg <= frame_close;
            item_data_reg  <= payload_byte;
        end
        if (emit)
        begin
            out_byte_reg  <= emit_byte;
            run_last_reg  <= emit_last;
            frame_end_reg <= emit_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

    // checks
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last)
        else $error("frame end beat without last flag");

    a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> !in_stall)
        else $error("input stalled with no item held");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> item_valid_reg)
        else $error("accepted beat not held");

    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !in_accept && phase_reg == PH_CHK_HI |=> crc_reg == CRC_INIT)
        else $error("crc not restarted after trailer");

endmodule

`default_nettype wire
